// ----- rtl/yaz0_pkg.sv -----
// ----------------------------------------------------------------------------
// yaz0_pkg
// Shared types and constants of the Yaz0 stream decompressor.
// ----------------------------------------------------------------------------
package yaz0_pkg;

  // Longest run of one element: an extended length byte of 255 plus 18.
  localparam int unsigned LEN_W       = 9;
  localparam int unsigned HDR_CNT_W   = 5;
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned DATA_W      = 64;
  localparam int unsigned SIZE_W      = 32;
  localparam int unsigned DIST_W      = 12;

  localparam logic [7:0]  LITERAL_FLAG = 8'h80;
  localparam logic [LEN_W-1:0] SHORT_LEN_BIAS = 9'd2;
  localparam logic [LEN_W-1:0] LONG_LEN_BIAS  = 9'd18;

  typedef enum logic [1:0] {
    PH_ELEMENT  = 2'd0,
    PH_PAIR_LO  = 2'd1,
    PH_EXT_LEN  = 2'd2
  } phase_t;

  // One run handed from the parser to the copy engine.
  typedef struct packed {
    logic              is_lit;
    logic [7:0]        lit;
    logic [LEN_W-1:0]  len;
    logic [DIST_W-1:0] offset;
    logic              fin;
  } copy_cmd_t;

endpackage

// ----- rtl/yaz0_in_if.sv -----
// ----------------------------------------------------------------------------
// yaz0_in_if
// Compressed byte channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface yaz0_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_start;

  modport source (output valid, output in_byte, output stream_start, input ready);
  modport sink   (input valid, input in_byte, input stream_start, output ready);
endinterface

// ----- rtl/yaz0_out_if.sv -----
// ----------------------------------------------------------------------------
// yaz0_out_if
// Decompressed result channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface yaz0_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_bytes;
  logic [3:0]  out_count;
  logic        run_last;
  logic        stream_done;

  modport source (output valid, output out_bytes, output out_count, output run_last,
                  output stream_done, input ready);
  modport sink   (input valid, input out_bytes, input out_count, input run_last,
                  input stream_done, output ready);
endinterface

// ----- rtl/yaz0_copy_engine.sv -----
// ----------------------------------------------------------------------------
// yaz0_copy_engine
// History window memory, byte-serial copy loop and result packing.
// ----------------------------------------------------------------------------
module yaz0_copy_engine #(
  parameter int unsigned HISTORY_DEPTH    = 4096,
  parameter int unsigned BYTES_PER_RESULT = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  clr,
  input  logic                  cmd_v,
  input  yaz0_pkg::copy_cmd_t   cmd,
  output logic                  busy,
  yaz0_out_if.source            out_ch
);

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);

  logic [7:0]                  mem [HISTORY_DEPTH];
  logic [AW-1:0]               wpos_r;
  logic [AW-1:0]               raddr_r;
  logic [yaz0_pkg::LEN_W-1:0]  issue_left_r;
  logic [yaz0_pkg::LEN_W-1:0]  abs_left_r;
  logic                        is_lit_r;
  logic [7:0]                  lit_r;
  logic                        fin_r;
  logic                        data_v_r;
  logic [7:0]                  rd_r;
  logic                        fwd_hit_r;
  logic [7:0]                  fwd_r;
  logic [yaz0_pkg::DATA_W-1:0] acc_r;
  logic [yaz0_pkg::CNT_W-1:0]  cnt_r;
  logic                        out_valid_r;
  logic [yaz0_pkg::DATA_W-1:0] out_bytes_r;
  logic [yaz0_pkg::CNT_W-1:0]  out_count_r;
  logic                        out_last_r;
  logic                        out_done_r;

  logic [7:0]                  byte_w;
  logic                        last_w;
  logic                        flush_w;
  logic                        out_free;
  logic                        absorb;
  logic                        issue;
  logic [AW-1:0]               base_w;
  logic [yaz0_pkg::DATA_W-1:0] acc_nxt;

  always_comb begin
    byte_w   = is_lit_r ? lit_r : (fwd_hit_r ? fwd_r : rd_r);
    last_w   = (abs_left_r == yaz0_pkg::LEN_W'(1));
    flush_w  = last_w || (cnt_r == yaz0_pkg::CNT_W'(BYTES_PER_RESULT - 1));
    out_free = !out_valid_r || out_ch.ready;
    absorb   = data_v_r && (!flush_w || out_free);
    issue    = (issue_left_r != '0) && (!data_v_r || absorb);
    base_w   = clr ? '0 : wpos_r;
    acc_nxt  = acc_r | (yaz0_pkg::DATA_W'(byte_w) << {cnt_r[2:0], 3'b000});
  end

  assign busy = (issue_left_r != '0) || data_v_r;

  // Memory: one write at the absorb point, one registered read per issue.
  // A read of the entry written in the same cycle takes the write data.
  always_ff @(posedge clk) begin
    if (absorb) begin
      mem[wpos_r] <= byte_w;
    end
    if (issue) begin
      rd_r      <= mem[raddr_r];
      fwd_hit_r <= absorb && (wpos_r == raddr_r);
      fwd_r     <= byte_w;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_v) begin
      is_lit_r <= cmd.is_lit;
      lit_r    <= cmd.lit;
      fin_r    <= cmd.fin;
    end
    if (absorb && flush_w) begin
      out_bytes_r <= acc_nxt;
      out_count_r <= cnt_r + yaz0_pkg::CNT_W'(1);
      out_last_r  <= last_w;
      out_done_r  <= last_w && fin_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wpos_r       <= '0;
      raddr_r      <= '0;
      issue_left_r <= '0;
      abs_left_r   <= '0;
      data_v_r     <= 1'b0;
      acc_r        <= '0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (clr) begin
        wpos_r <= '0;
      end else if (absorb) begin
        wpos_r <= wpos_r + AW'(1);
      end
      if (cmd_v) begin
        issue_left_r <= cmd.len;
        abs_left_r   <= cmd.len;
        raddr_r      <= base_w - AW'(cmd.offset);
      end else begin
        if (issue) begin
          issue_left_r <= issue_left_r - yaz0_pkg::LEN_W'(1);
          raddr_r      <= raddr_r + AW'(1);
        end
        if (absorb) begin
          abs_left_r <= abs_left_r - yaz0_pkg::LEN_W'(1);
        end
      end
      if (issue) begin
        data_v_r <= 1'b1;
      end else if (absorb) begin
        data_v_r <= 1'b0;
      end
      if (absorb) begin
        if (flush_w) begin
          acc_r <= '0;
          cnt_r <= '0;
        end else begin
          acc_r <= acc_nxt;
          cnt_r <= cnt_r + yaz0_pkg::CNT_W'(1);
        end
      end
      if (absorb && flush_w) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_bytes   = out_bytes_r;
  assign out_ch.out_count   = out_count_r;
  assign out_ch.run_last    = out_last_r;
  assign out_ch.stream_done = out_done_r;

  a_cmd_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_v |-> !busy) else $error("run command while engine busy");

  a_issue_ahead: assert property (@(posedge clk) disable iff (!rst_n)
    (abs_left_r - issue_left_r) <= yaz0_pkg::LEN_W'(1))
    else $error("more than one byte in flight");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (absorb && last_w) |=> (abs_left_r == '0) && !data_v_r)
    else $error("run did not end after its last byte");

  a_pack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < yaz0_pkg::CNT_W'(BYTES_PER_RESULT))
    else $error("packing count overflow");

endmodule

// ----- rtl/yaz0_stream_decompressor_core.sv -----
// ----------------------------------------------------------------------------
// yaz0_stream_decompressor_core
// Yaz0 decompressor: parses the compressed byte stream and expands it
// through a history window into packed result items.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake        Payload
//  in_ch     in         valid / ready    in_byte[7:0], stream_start
//  out_ch    out        valid / ready    out_bytes[63:0], out_count[3:0],
//                                        run_last, stream_done
//  cfg_*     in         cfg_we           cfg_wdata[31:0] (output_size)
//
// Header, flag and pair bytes that produce no output leave the engine idle.
// A literal or a copy of N bytes occupies the copy engine until its last
// byte is absorbed; the history memory delivers one byte per cycle through
// its single read port unless out_ch stalls; in_ch.ready is low meanwhile.
// Reset (rst_n low, synchronous) clears the parser and the engine; the history
// memory is not cleared and holds no valid bits.
// A stalled out_ch holds the engine once the next result item is complete,
// while one finished item waits in the output register.
//
module yaz0_stream_decompressor_core #(
  parameter int unsigned HISTORY_DEPTH    = 4096,
  parameter int unsigned HEADER_BYTES     = 16,
  parameter int unsigned BYTES_PER_RESULT = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [yaz0_pkg::SIZE_W-1:0]   cfg_wdata,
  yaz0_in_if.sink                       in_ch,
  yaz0_out_if.source                    out_ch
);

  logic [yaz0_pkg::SIZE_W-1:0]    output_size_r;
  logic [yaz0_pkg::HDR_CNT_W-1:0] header_left_r, header_left_nxt;
  logic [7:0]                     group_flags_r, group_flags_nxt;
  logic [3:0]                     flags_left_r, flags_left_nxt;
  yaz0_pkg::phase_t               phase_r, phase_nxt;
  logic [7:0]                     pair_first_r, pair_first_nxt;
  logic [7:0]                     pair_second_r, pair_second_nxt;
  logic [yaz0_pkg::SIZE_W-1:0]    produced_r, produced_nxt;

  // Values after an optional stream_start clear.
  logic [yaz0_pkg::HDR_CNT_W-1:0] hl_e;
  logic [7:0]                     gf_e;
  logic [3:0]                     fl_e;
  yaz0_pkg::phase_t               ph_e;
  logic [7:0]                     pf_e;
  logic [yaz0_pkg::SIZE_W-1:0]    pr_e;

  logic                           accept;
  logic                           busy;
  logic                           run_v;
  logic                           run_lit;
  logic [yaz0_pkg::LEN_W-1:0]     run_len;
  logic [yaz0_pkg::SIZE_W-1:0]    room;
  logic [yaz0_pkg::LEN_W-1:0]     len_t;
  logic                           cmd_v;
  logic                           clr;
  yaz0_pkg::copy_cmd_t            cmd;

  assign in_ch.ready = !busy;
  assign accept      = in_ch.valid && in_ch.ready;
  assign clr         = accept && in_ch.stream_start;

  always_comb begin
    if (in_ch.stream_start) begin
      hl_e = yaz0_pkg::HDR_CNT_W'(HEADER_BYTES);
      gf_e = '0;
      fl_e = '0;
      ph_e = yaz0_pkg::PH_ELEMENT;
      pf_e = '0;
      pr_e = '0;
    end else begin
      hl_e = header_left_r;
      gf_e = group_flags_r;
      fl_e = flags_left_r;
      ph_e = phase_r;
      pf_e = pair_first_r;
      pr_e = produced_r;
    end

    header_left_nxt = hl_e;
    group_flags_nxt = gf_e;
    flags_left_nxt  = fl_e;
    phase_nxt       = ph_e;
    pair_first_nxt  = pf_e;
    pair_second_nxt = in_ch.stream_start ? 8'h00 : pair_second_r;
    run_v           = 1'b0;
    run_lit         = 1'b0;
    run_len         = '0;

    if (hl_e != '0) begin
      header_left_nxt = hl_e - yaz0_pkg::HDR_CNT_W'(1);
    end else if (pr_e >= output_size_r) begin
      // Stream finished: the byte is dropped.
    end else begin
      case (ph_e)
        yaz0_pkg::PH_ELEMENT: begin
          if (fl_e == '0) begin
            group_flags_nxt = in_ch.in_byte;
            flags_left_nxt  = 4'd8;
          end else if ((gf_e & yaz0_pkg::LITERAL_FLAG) != '0) begin
            run_v   = 1'b1;
            run_lit = 1'b1;
            run_len = yaz0_pkg::LEN_W'(1);
          end else begin
            pair_first_nxt = in_ch.in_byte;
            phase_nxt      = yaz0_pkg::PH_PAIR_LO;
          end
        end
        yaz0_pkg::PH_PAIR_LO: begin
          pair_second_nxt = in_ch.in_byte;
          if (pf_e[7:4] == 4'd0) begin
            phase_nxt = yaz0_pkg::PH_EXT_LEN;
          end else begin
            run_v     = 1'b1;
            run_len   = yaz0_pkg::LEN_W'(pf_e[7:4]) + yaz0_pkg::SHORT_LEN_BIAS;
            phase_nxt = yaz0_pkg::PH_ELEMENT;
          end
        end
        yaz0_pkg::PH_EXT_LEN: begin
          run_v     = 1'b1;
          run_len   = yaz0_pkg::LEN_W'(in_ch.in_byte) + yaz0_pkg::LONG_LEN_BIAS;
          phase_nxt = yaz0_pkg::PH_ELEMENT;
        end
        default: begin
          phase_nxt = yaz0_pkg::PH_ELEMENT;
        end
      endcase
      if (run_v) begin
        // Each literal or back-reference consumes one flag bit.
        group_flags_nxt = {gf_e[6:0], 1'b0};
        if (fl_e != '0) begin
          flags_left_nxt = fl_e - 4'd1;
        end
      end
    end

    // A run is cut off at the configured size.
    room  = output_size_r - pr_e;
    len_t = (room < yaz0_pkg::SIZE_W'(run_len)) ? room[yaz0_pkg::LEN_W-1:0] : run_len;
    produced_nxt = run_v ? pr_e + yaz0_pkg::SIZE_W'(len_t) : pr_e;

    cmd.is_lit = run_lit;
    cmd.lit    = in_ch.in_byte;
    cmd.len    = len_t;
    // The distance is stored minus one; wrap it to the window width.
    cmd.offset = {pf_e[3:0], (phase_r == yaz0_pkg::PH_PAIR_LO) ? in_ch.in_byte
                                                                : pair_second_r}
                 + yaz0_pkg::DIST_W'(1);
    cmd.fin    = (yaz0_pkg::SIZE_W'(run_len) >= room);
  end

  assign cmd_v = accept && run_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      output_size_r <= '0;
      header_left_r <= yaz0_pkg::HDR_CNT_W'(HEADER_BYTES);
      group_flags_r <= '0;
      flags_left_r  <= '0;
      phase_r       <= yaz0_pkg::PH_ELEMENT;
      pair_first_r  <= '0;
      pair_second_r <= '0;
      produced_r    <= '0;
    end else begin
      if (cfg_we) begin
        output_size_r <= cfg_wdata;
      end
      if (accept) begin
        header_left_r <= header_left_nxt;
        group_flags_r <= group_flags_nxt;
        flags_left_r  <= flags_left_nxt;
        phase_r       <= phase_nxt;
        pair_first_r  <= pair_first_nxt;
        pair_second_r <= pair_second_nxt;
        produced_r    <= produced_nxt;
      end
    end
  end

  yaz0_copy_engine #(
    .HISTORY_DEPTH    (HISTORY_DEPTH),
    .BYTES_PER_RESULT (BYTES_PER_RESULT)
  ) u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .clr    (clr),
    .cmd_v  (cmd_v),
    .cmd    (cmd),
    .busy   (busy),
    .out_ch (out_ch)
  );

  a_no_run_in_header: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_ch.stream_start && header_left_r != '0) |-> !cmd_v)
    else $error("run started inside header");

  a_produced_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_v |-> (produced_nxt <= output_size_r))
    else $error("run exceeds output size");

  a_run_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_v |-> (cmd.len != '0)) else $error("empty run issued");

endmodule
